[sv/erm_pkg.sv]
// Shared types, constants and arithmetic helpers of the Euler rotation matrix unit.
// Depends on nothing; every module of the unit imports it.
`timescale 1ns / 1ps

package erm_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int COEF_BITS  = 16;
    localparam int IFRAC      = 30;
    localparam int ANG_SHIFT  = IFRAC - (ANGLE_BITS - 4);
    localparam int NUM_STEPS  = 5;
    localparam int PIPE_DEPTH = 23;

    localparam logic [30:0] ONE = 31'h4000_0000;
    localparam logic signed [35:0] PI_QUARTER = 36'sd843314857;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } t_rot;

    typedef struct packed {
        logic signed [31:0] r;
        logic [1:0]         quad;
        logic [30:0]        r2;
        logic [30:0]        ps;
        logic [30:0]        pc;
    } t_lane;

    typedef struct packed {
        logic [6:0]  div_s;
        logic [31:0] recip_s;
        logic        on_s;
        logic [6:0]  div_c;
        logic [31:0] recip_c;
    } t_step;

    // Multiples of pi/2 for quadrant counts 0 to 10, i.e. quadrants -5 to 5.
    function automatic logic signed [35:0] qph(input logic [3:0] cnt);
        logic signed [35:0] v;
        case (cnt)
            4'd0:    v = -36'sd8433148565;
            4'd1:    v = -36'sd6746518852;
            4'd2:    v = -36'sd5059889139;
            4'd3:    v = -36'sd3373259426;
            4'd4:    v = -36'sd1686629713;
            4'd5:    v = 36'sd0;
            4'd6:    v = 36'sd1686629713;
            4'd7:    v = 36'sd3373259426;
            4'd8:    v = 36'sd5059889139;
            4'd9:    v = 36'sd6746518852;
            4'd10:   v = 36'sd8433148565;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

    // Series divisors and their reciprocals scaled by 2^32, one entry per step.
    function automatic t_step step_const(input logic [2:0] k);
        t_step s;
        case (k)
            3'd0:    s = '{7'd72, 32'd59652323,  1'b1, 7'd90, 32'd47721858};
            3'd1:    s = '{7'd42, 32'd102261126, 1'b1, 7'd56, 32'd76695844};
            3'd2:    s = '{7'd20, 32'd214748364, 1'b1, 7'd30, 32'd143165576};
            3'd3:    s = '{7'd6,  32'd715827882, 1'b1, 7'd12, 32'd357913941};
            3'd4:    s = '{7'd1,  32'd0,         1'b0, 7'd2,  32'd2147483648};
            default: s = '{7'd1,  32'd0,         1'b0, 7'd1,  32'd0};
        endcase
        return s;
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[61:30];
    endfunction

    function automatic logic signed [15:0] sat_round(input logic signed [33:0] v);
        logic signed [33:0] t;
        logic signed [15:0] o;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384) begin
            o = 16'sd16384;
        end else if (t < -34'sd16384) begin
            o = -16'sd16384;
        end else begin
            o = t[15:0];
        end
        return o;
    endfunction

endpackage

[sv/erm_reduce_cell.sv]
// Range reduction cell: quadrant count, remainder and remainder squared.
// Depends on erm_pkg.
`timescale 1ns / 1ps

module erm_reduce_cell import erm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output t_lane              o_lane
);

    logic signed [35:0] n_a;
    logic signed [35:0] r_a;
    logic [3:0]         n_cnt;
    logic [3:0]         r_cnt;
    logic signed [35:0] v;
    logic signed [35:0] diff;
    logic signed [31:0] r_r;
    logic [1:0]         r_quad;
    logic signed [63:0] sq;
    t_lane              r_lane;

    always_comb begin
        n_a   = 36'(i_angle) <<< ANG_SHIFT;
        v     = n_a + PI_QUARTER;
        n_cnt = 4'd0;
        for (int j = 1; j <= 10; j++) begin
            n_cnt = n_cnt + 4'(v >= qph(4'(j)));
        end
        diff = r_a - qph(r_cnt);
        sq   = r_r * r_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a         <= n_a;
            r_cnt       <= n_cnt;
            r_r         <= diff[31:0];
            r_quad      <= 2'(r_cnt + 4'd3);
            r_lane.r    <= r_r;
            r_lane.quad <= r_quad;
            r_lane.r2   <= sq[60:30];
            r_lane.ps   <= ONE;
            r_lane.pc   <= ONE;
        end
    end

    assign o_lane = r_lane;

endmodule

[sv/erm_series_cell.sv]
// One Horner step of the sine and cosine series, three register stages deep.
// Depends on erm_pkg.
`timescale 1ns / 1ps

module erm_series_cell import erm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_step i_step,
    input  t_lane i_lane,
    output t_lane o_lane
);

    logic [61:0] prod_s, prod_c;
    logic [62:0] t_s, t_c;
    logic [37:0] rem_s, rem_c;
    logic [30:0] q_s, q_c;
    t_lane       r_a_lane, r_b_lane, r_c_lane, n_c_lane;
    logic [30:0] r_a_xs, r_a_xc, r_b_xs, r_b_xc, r_b_qs, r_b_qc;

    always_comb begin
        prod_s = 62'(i_lane.r2) * 62'(i_lane.ps);
        prod_c = 62'(i_lane.r2) * 62'(i_lane.pc);
        t_s    = 63'(r_a_xs) * 63'(i_step.recip_s);
        t_c    = 63'(r_a_xc) * 63'(i_step.recip_c);
        rem_s  = 38'(r_b_xs) - 38'(r_b_qs) * 38'(i_step.div_s);
        rem_c  = 38'(r_b_xc) - 38'(r_b_qc) * 38'(i_step.div_c);
        q_s    = r_b_qs + 31'(rem_s >= 38'(i_step.div_s));
        q_c    = r_b_qc + 31'(rem_c >= 38'(i_step.div_c));
        n_c_lane    = r_b_lane;
        n_c_lane.pc = ONE - q_c;
        if (i_step.on_s) begin
            n_c_lane.ps = ONE - q_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_lane <= i_lane;
            r_a_xs   <= prod_s[60:30];
            r_a_xc   <= prod_c[60:30];
            r_b_lane <= r_a_lane;
            r_b_xs   <= r_a_xs;
            r_b_xc   <= r_a_xc;
            r_b_qs   <= t_s[62:32];
            r_b_qc   <= t_c[62:32];
            r_c_lane <= n_c_lane;
        end
    end

    assign o_lane = r_c_lane;

endmodule

[sv/erm_sincos.sv]
// Sine and cosine of one angle: reduction cell, a row of series cells, quadrant fix-up.
// Depends on erm_pkg, erm_reduce_cell and erm_series_cell.
`timescale 1ns / 1ps

module erm_sincos import erm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    t_lane              lanes [NUM_STEPS+1];
    logic signed [31:0] s, c;
    logic signed [31:0] r_sin, r_cos;

    erm_reduce_cell u_reduce (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_angle (i_angle),
        .o_lane  (lanes[0])
    );

    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_cell
        erm_series_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_step (step_const(3'(k))),
            .i_lane (lanes[k]),
            .o_lane (lanes[k+1])
        );
    end

    always_comb begin
        s = fx_mul(lanes[NUM_STEPS].r, 32'({1'b0, lanes[NUM_STEPS].ps}));
        c = 32'({1'b0, lanes[NUM_STEPS].pc});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (lanes[NUM_STEPS].quad)
                2'd0: begin
                    r_sin <= s;
                    r_cos <= c;
                end
                2'd1: begin
                    r_sin <= c;
                    r_cos <= -s;
                end
                2'd2: begin
                    r_sin <= -s;
                    r_cos <= -c;
                end
                default: begin
                    r_sin <= -c;
                    r_cos <= s;
                end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[sv/erm_matrix.sv]
// Closed-form 3x3 rotation from the three sine and cosine pairs, three stages deep.
// Depends on erm_pkg.
`timescale 1ns / 1ps

module erm_matrix import erm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_sx,
    input  logic signed [31:0] i_cx,
    input  logic signed [31:0] i_sy,
    input  logic signed [31:0] i_cy,
    input  logic signed [31:0] i_sz,
    input  logic signed [31:0] i_cz,
    output t_rot               o_rot
);

    logic signed [31:0] r_sxsy, r_cxsy, r_cycz, r_cysz, r_cxsz, r_cxcz;
    logic signed [31:0] r_sxcy, r_sxsz, r_sxcz, r_cxcy, r_sy, r_sz, r_cz;
    logic signed [31:0] r2_cycz, r2_cysz, r2_cxsz, r2_cxcz, r2_sxcy, r2_sxsz;
    logic signed [31:0] r2_sxcz, r2_cxcy, r2_sy;
    logic signed [31:0] r2_sxsycz, r2_sxsysz, r2_cxsycz, r2_cxsysz;
    t_rot               n_rot, r_rot;

    always_comb begin
        n_rot.r00 = sat_round(34'(r2_cycz));
        n_rot.r01 = sat_round(-34'(r2_cysz));
        n_rot.r02 = sat_round(34'(r2_sy));
        n_rot.r10 = sat_round(34'(r2_sxsycz) + 34'(r2_cxsz));
        n_rot.r11 = sat_round(34'(r2_cxcz) - 34'(r2_sxsysz));
        n_rot.r12 = sat_round(-34'(r2_sxcy));
        n_rot.r20 = sat_round(34'(r2_sxsz) - 34'(r2_cxsycz));
        n_rot.r21 = sat_round(34'(r2_cxsysz) + 34'(r2_sxcz));
        n_rot.r22 = sat_round(34'(r2_cxcy));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sxsy    <= fx_mul(i_sx, i_sy);
            r_cxsy    <= fx_mul(i_cx, i_sy);
            r_cycz    <= fx_mul(i_cy, i_cz);
            r_cysz    <= fx_mul(i_cy, i_sz);
            r_cxsz    <= fx_mul(i_cx, i_sz);
            r_cxcz    <= fx_mul(i_cx, i_cz);
            r_sxcy    <= fx_mul(i_sx, i_cy);
            r_sxsz    <= fx_mul(i_sx, i_sz);
            r_sxcz    <= fx_mul(i_sx, i_cz);
            r_cxcy    <= fx_mul(i_cx, i_cy);
            r_sy      <= i_sy;
            r_sz      <= i_sz;
            r_cz      <= i_cz;
            r2_sxsycz <= fx_mul(r_sxsy, r_cz);
            r2_sxsysz <= fx_mul(r_sxsy, r_sz);
            r2_cxsycz <= fx_mul(r_cxsy, r_cz);
            r2_cxsysz <= fx_mul(r_cxsy, r_sz);
            r2_cycz   <= r_cycz;
            r2_cysz   <= r_cysz;
            r2_cxsz   <= r_cxsz;
            r2_cxcz   <= r_cxcz;
            r2_sxcy   <= r_sxcy;
            r2_sxsz   <= r_sxsz;
            r2_sxcz   <= r_sxcz;
            r2_cxcy   <= r_cxcy;
            r2_sy     <= r_sy;
            r_rot     <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

[sv/euler_xyz_rotation_matrix_unit.sv]
// Top level of the Euler x-y-z rotation matrix unit.
// Throughput is one item per cycle when the output does not stall. The stage count is set by
// the input register, range reduction, five three-stage series cells, fix-up and the matrix.
// The whole pipeline stalls when the output holds an untaken result; the input stage still
// takes one more item if it is empty. Synchronous active-low reset clears only the valid bits.
// Depends on erm_pkg, erm_sincos and erm_matrix.
`timescale 1ns / 1ps

module euler_xyz_rotation_matrix_unit import erm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_angles i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_rot    o_out_data
);

    logic [PIPE_DEPTH-1:0] r_vld;
    t_angles               r_in;
    logic                  en, load;
    logic signed [31:0]    sx, cx, sy, cy, sz, cz;

    assign en   = ~r_vld[PIPE_DEPTH-1] | i_out_ready;
    assign load = en | ~r_vld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (load) begin
                r_vld[0] <= i_in_valid;
            end
            if (en) begin
                r_vld[PIPE_DEPTH-1:1] <= r_vld[PIPE_DEPTH-2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in <= i_in_data;
        end
    end

    erm_sincos u_sc_x (
        .i_clk(i_clk), .i_en(en), .i_angle(r_in.angle_x), .o_sin(sx), .o_cos(cx)
    );

    erm_sincos u_sc_y (
        .i_clk(i_clk), .i_en(en), .i_angle(r_in.angle_y), .o_sin(sy), .o_cos(cy)
    );

    erm_sincos u_sc_z (
        .i_clk(i_clk), .i_en(en), .i_angle(r_in.angle_z), .o_sin(sz), .o_cos(cz)
    );

    erm_matrix u_matrix (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sx  (sx),
        .i_cx  (cx),
        .i_sy  (sy),
        .i_cy  (cy),
        .i_sz  (sz),
        .i_cz  (cz),
        .o_rot (o_out_data)
    );

    assign o_in_ready  = load;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

endmodule
